// ===== rtl/irsc_pkg.sv =====
// ----------------------------------------------------------------------------
// irsc_pkg
// Types and codes shared by the instance record stream checker.
// ----------------------------------------------------------------------------
package irsc_pkg;

  // largest legal cell coordinate or ordinal
  localparam logic [15:0] CELL_LIMIT = 16'd255;
  localparam int WORD_BITS = 64;

  // configuration register indexes
  localparam logic [1:0] REG_SPECIES_COUNT = 2'd0;
  localparam logic [1:0] REG_MIN_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_MAX_HEIGHT    = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_RECORD = 3'd1;
  localparam logic [2:0] ST_UNSORTED   = 3'd2;
  localparam logic [2:0] ST_EXTREMA    = 3'd3;
  localparam logic [2:0] ST_UNREF      = 3'd4;

  localparam logic [15:0] NORMAL_INVALID = 16'h8000;

  typedef struct packed {
    logic [15:0]        species_id;
    logic [15:0]        cell_x;
    logic [15:0]        cell_z;
    logic [15:0]        ordinal;
    logic [15:0]        scale_value;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [31:0] height_mm;
    logic [31:0]        reserved_word;
    logic               last_record;
  } rec_t;

  typedef struct packed {
    logic [2:0] status;
    logic       chunk_done;
  } res_t;

endpackage

// ===== rtl/instance_record_stream_checker.sv =====
// ----------------------------------------------------------------------------
// instance_record_stream_checker
// Checks one chunk's stream of instance records and reports a status per word.
// ----------------------------------------------------------------------------
// Records come in on the rec channel, one word per record, and every record
// yields exactly one word on the res channel. Both use valid/stall: a word
// moves on an edge with valid high and stall low.
// An ordinary record is taken every cycle while the result word can move on;
// its status word is registered and shows up in the cycle after acceptance.
// Range, order and extrema checks run on the accepting edge; the species
// bitmap lives in a MAP_WORDS x 64 memory with registered reads, updated by
// read-modify-write with one-deep forwarding. A record with last_record set
// starts a sweep of the bitmap: one memory word per cycle,
// ceil(species_total/64) words (at most MAP_WORDS), that checks for
// unreferenced species and zeroes each word. The final word with chunk_done
// set is loaded once the last swept word has been checked and the result
// word is free (the sweep is skipped when the species total is zero); no
// record is taken until then. After reset a clearing pass zeroes the bitmap
// word by word with rec_stall high; configuration writes are taken at any time.
// While res_stall is high the result word holds and rec_stall rises once a
// new result would have nowhere to go. The user must write configuration only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module instance_record_stream_checker
  import irsc_pkg::*;
#(
  parameter int MAP_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rec_valid,
  output logic        rec_stall,
  input  rec_t        rec,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int MapSpecies = MAP_WORDS * WORD_BITS;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // configuration
  logic [15:0]        species_total;
  logic signed [31:0] height_lo;
  logic signed [31:0] height_hi;

  // chunk state
  logic [1:0]         state;
  logic               have_prior;
  logic [15:0]        prior_species;
  logic [23:0]        prior_key;
  logic signed [31:0] seen_min;
  logic signed [31:0] seen_max;
  logic [2:0]         err;
  logic [AW-1:0]      clr_cnt;
  logic [AW-1:0]      sw_cnt;

  // bitmap memory and its pipeline
  logic [63:0]   mem [MAP_WORDS];
  logic [63:0]   rd_data;
  logic          b_valid;
  logic          b_sweep;
  logic [AW-1:0] b_addr;
  logic [5:0]    b_bit;
  logic          lw_valid;
  logic [AW-1:0] lw_addr;
  logic [63:0]   lw_data;

  logic          res_free;
  logic          acc;
  logic          bad;
  logic          ordered;
  logic          good;
  logic [23:0]   key;
  logic [2:0]    err_next;
  logic [2:0]    err_last;
  logic signed [31:0] seen_min_next;
  logic signed [31:0] seen_max_next;
  logic [AW-1:0] rec_addr;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic [63:0]   fwd_data;
  logic [10:0]   sc_words;
  logic [10:0]   sw_cap;
  logic [AW-1:0] sw_last;
  logic [9:0]    b_word;
  logic [63:0]   b_mask;
  logic          missing;
  logic          done_fire;

  assign res_free  = !res_valid || !res_stall;
  assign rec_stall = !(state == S_RUN && res_free);
  assign acc       = rec_valid && !rec_stall;

  // record checks
  assign key = {rec.cell_z[7:0], rec.cell_x[7:0], rec.ordinal[7:0]};

  always_comb begin
    bad = (rec.species_id >= species_total) ||
          (17'(rec.species_id) >= 17'(MapSpecies)) ||
          (rec.cell_x > CELL_LIMIT) || (rec.cell_z > CELL_LIMIT) ||
          (rec.ordinal > CELL_LIMIT) || (rec.scale_value == 16'd0) ||
          (rec.normal_x == NORMAL_INVALID) || (rec.normal_y == NORMAL_INVALID) ||
          (rec.reserved_word != 32'd0) ||
          (rec.height_mm < height_lo) || (rec.height_mm > height_hi);
    ordered = !have_prior || (rec.species_id > prior_species) ||
              (rec.species_id == prior_species && key > prior_key);
    good = (err == ST_OK) && !bad && ordered;

    err_next = err;
    if (err == ST_OK) begin
      if (bad) begin
        err_next = ST_BAD_RECORD;
      end else if (!ordered) begin
        err_next = ST_UNSORTED;
      end
    end

    seen_min_next = (good && rec.height_mm < seen_min) ? rec.height_mm : seen_min;
    seen_max_next = (good && rec.height_mm > seen_max) ? rec.height_mm : seen_max;

    // verdict known before the sweep
    err_last = err_next;
    if (err_next == ST_OK) begin
      if (seen_min_next != height_lo || seen_max_next != height_hi) begin
        err_last = ST_EXTREMA;
      end else if (17'(species_total) > 17'(MapSpecies)) begin
        err_last = ST_UNREF;
      end
    end
  end

  // sweep length
  assign sc_words = 11'((17'(species_total) + 17'd63) >> 6);
  assign sw_cap   = (sc_words > 11'(MAP_WORDS)) ? 11'(MAP_WORDS) : sc_words;
  assign sw_last  = AW'(sw_cap - 11'd1);

  // memory ports
  assign rec_addr = AW'(rec.species_id[15:6]);
  assign rd_addr  = (state == S_SWEEP) ? sw_cnt : rec_addr;
  assign fwd_data = (lw_valid && lw_addr == b_addr) ? lw_data : rd_data;

  always_comb begin
    b_word = 10'(b_addr);
    if (b_word < species_total[15:6]) begin
      b_mask = '1;
    end else if (b_word == species_total[15:6]) begin
      b_mask = (64'd1 << species_total[5:0]) - 64'd1;
    end else begin
      b_mask = '0;
    end
    missing = (fwd_data & b_mask) != b_mask;
  end

  always_comb begin
    wr_en   = (state == S_CLEAR) || b_valid;
    wr_addr = (state == S_CLEAR) ? clr_cnt : b_addr;
    if (state == S_CLEAR || b_sweep) begin
      wr_data = '0;
    end else begin
      wr_data = fwd_data | (64'd1 << b_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
    lw_addr <= wr_addr;
    lw_data <= wr_data;
  end

  assign done_fire = (state == S_DONE) && !b_valid && res_free;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      species_total <= 16'd1;
      height_lo     <= '0;
      height_hi     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPECIES_COUNT: species_total <= cfg_data[15:0];
        REG_MIN_HEIGHT:    height_lo     <= cfg_data;
        REG_MAX_HEIGHT:    height_hi     <= cfg_data;
        default: ;
      endcase
    end
  end

  // control and chunk state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      sw_cnt     <= '0;
      have_prior <= 1'b0;
      prior_species <= '0;
      prior_key  <= '0;
      seen_min   <= 32'sh7FFF_FFFF;
      seen_max   <= 32'sh8000_0000;
      err        <= ST_OK;
      b_valid    <= 1'b0;
      b_sweep    <= 1'b0;
      lw_valid   <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      lw_valid <= wr_en;
      b_valid  <= 1'b0;
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      // sweep check of the word read last cycle
      if (b_valid && b_sweep && missing && err == ST_OK) begin
        err <= ST_UNREF;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MAP_WORDS - 1)) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (acc) begin
            b_valid <= good;
            b_sweep <= 1'b0;
            if (good) begin
              prior_species <= rec.species_id;
              prior_key     <= key;
              have_prior    <= 1'b1;
            end
            seen_min <= seen_min_next;
            seen_max <= seen_max_next;
            if (rec.last_record) begin
              err           <= err_last;
              have_prior    <= 1'b0;
              prior_species <= '0;
              prior_key     <= '0;
              seen_min      <= 32'sh7FFF_FFFF;
              seen_max      <= 32'sh8000_0000;
              sw_cnt        <= '0;
              state         <= (sw_cap == 11'd0) ? S_DONE : S_SWEEP;
            end else begin
              err       <= err_next;
              res_valid <= 1'b1;
              res       <= '{status: err_next, chunk_done: 1'b0};
            end
          end
        end
        S_SWEEP: begin
          b_valid <= 1'b1;
          b_sweep <= 1'b1;
          sw_cnt  <= sw_cnt + AW'(1);
          if (sw_cnt == sw_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            res_valid <= 1'b1;
            res       <= '{status: err, chunk_done: 1'b1};
            err       <= ST_OK;
            state     <= S_RUN;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SWEEP) begin
      b_addr <= sw_cnt;
    end else begin
      b_addr <= rec_addr;
    end
    b_bit <= rec.species_id[5:0];
  end

  // ---- assertions ----
  a_no_accept_outside_run: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && !rec_stall) |-> (state == S_RUN))
    else $error("record accepted outside run state");

  a_clear_no_pipe: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !b_valid)
    else $error("bitmap update during clearing pass");

  a_sweep_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |=> (state == S_SWEEP || state == S_DONE))
    else $error("sweep left without final verdict");

  a_final_word: assert property (@(posedge clk) disable iff (rst)
    done_fire |=> (res_valid && res.chunk_done && err == ST_OK && state == S_RUN))
    else $error("final word not issued or error not cleared");

  a_plain_word: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && !rec_stall && !rec.last_record) |=> (res_valid && !res.chunk_done))
    else $error("ordinary record gave no plain result word");

endmodule
